@@ rtl/stad_pkg.sv @@
`default_nettype none
package stad_pkg;

	localparam int EXT_W = 16;
	localparam int BASE_W = 32;
	localparam int INDEX_W = 48;
	localparam int PROD_W = 32;
	localparam int OFFSET_W = 34;
	localparam int Q1_BITS = 32;
	localparam int Q2_BITS = 16;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_LOGICAL = 2'd1;
	localparam logic [1:0] ERR_COORD = 2'd2;
	localparam logic [1:0] ERR_SCALAR = 2'd3;

	localparam logic [2:0] REG_NUM_DIMS = 3'd0;
	localparam logic [2:0] REG_BASE_OFFSET = 3'd1;
	localparam logic [2:0] REG_EXTENT_0 = 3'd2;
	localparam logic [2:0] REG_EXTENT_1 = 3'd3;
	localparam logic [2:0] REG_EXTENT_2 = 3'd4;
	localparam logic [2:0] REG_STRIDE_0 = 3'd5;
	localparam logic [2:0] REG_STRIDE_1 = 3'd6;
	localparam logic [2:0] REG_STRIDE_2 = 3'd7;

	// The view seen from the innermost dimension outward. Unused outer
	// positions are padded with extent 1 and stride 0.
	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [EXT_W-1:0]  ext_in;
		logic [EXT_W-1:0]  ext_mid;
		logic [EXT_W-1:0]  ext_out;
		logic [EXT_W-1:0]  str_in;
		logic [EXT_W-1:0]  str_mid;
		logic [EXT_W-1:0]  str_out;
	} view_t;

	typedef struct packed {
		logic             cmd;
		logic [1:0]       err;
		logic [EXT_W-1:0] c_in;
		logic [EXT_W-1:0] c_mid;
		logic [EXT_W-1:0] c_out;
	} pass_t;

	function automatic view_t map_view(input logic [1:0] n, input logic [BASE_W-1:0] base,
			input logic [EXT_W-1:0] e0, input logic [EXT_W-1:0] e1,
			input logic [EXT_W-1:0] e2, input logic [EXT_W-1:0] s0,
			input logic [EXT_W-1:0] s1, input logic [EXT_W-1:0] s2);
		view_t v;
		v.base = base;
		unique case (n)
			2'd3: begin
				v.ext_in = e2; v.ext_mid = e1; v.ext_out = e0;
				v.str_in = s2; v.str_mid = s1; v.str_out = s0;
			end
			2'd2: begin
				v.ext_in = e1; v.ext_mid = e0; v.ext_out = EXT_W'(1);
				v.str_in = s1; v.str_mid = s0; v.str_out = '0;
			end
			2'd1: begin
				v.ext_in = e0; v.ext_mid = EXT_W'(1); v.ext_out = EXT_W'(1);
				v.str_in = s0; v.str_mid = '0; v.str_out = '0;
			end
			default: begin
				v.ext_in = EXT_W'(1); v.ext_mid = EXT_W'(1); v.ext_out = EXT_W'(1);
				v.str_in = '0; v.str_mid = '0; v.str_out = '0;
			end
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ rtl/stad_div_step.sv @@
`default_nettype none
module stad_div_step import stad_pkg::*; #(
	parameter int K = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [EXT_W+K-1:0]   in_word,
	input  wire pass_t                in_pass,
	input  wire logic [EXT_W-1:0]     divisor,
	output logic                      out_valid,
	output logic [EXT_W+K-1:0]        out_word,
	output pass_t                     out_pass
);

	// The word holds the partial remainder on top and the dividend bits still
	// to be consumed below; quotient bits shift in at the bottom.
	logic [EXT_W:0]   trial;
	logic [EXT_W:0]   diff;
	logic             take;
	logic [EXT_W-1:0] rem_n;
	logic             valid_s1;
	logic [EXT_W+K-1:0] word_s1;
	pass_t            pass_s1;

	assign trial = {in_word[EXT_W+K-1:K], in_word[K-1]};
	assign diff = trial - {1'b0, divisor};
	assign take = trial >= {1'b0, divisor};
	assign rem_n = take ? diff[EXT_W-1:0] : trial[EXT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= {rem_n, in_word[K-2:0], take};
			pass_s1 <= in_pass;
		end
	end

	assign out_valid = valid_s1;
	assign out_word = word_s1;
	assign out_pass = pass_s1;

endmodule
`default_nettype wire

@@ rtl/stad_front.sv @@
`default_nettype none
module stad_front import stad_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic               cmd,
	input  wire logic [INDEX_W-1:0] logical_index,
	input  wire logic [EXT_W-1:0]   coord_0,
	input  wire logic [EXT_W-1:0]   coord_1,
	input  wire logic [EXT_W-1:0]   coord_2,
	input  wire logic [1:0]         n_act,
	input  wire view_t              view,
	output logic                    out_valid,
	output logic [INDEX_W-1:0]      out_index,
	output pass_t                   out_pass
);

	logic               valid_s1, valid_s2, valid_s3;
	logic               cmd_s1;
	logic [INDEX_W-1:0] li_s1, li_s2, li_s3;
	logic [EXT_W-1:0]   c0_s1, c1_s1, c2_s1;
	pass_t              pass_s2, pass_s3;
	pass_t              pass_n;
	pass_t              pass3_n;
	logic [PROD_W-1:0]  part_q;
	logic [INDEX_W-1:0] count_q;
	logic [1:0]         err3;

	// Element count follows the configuration through the registers part_q and
	// count_q; it is first used by an item in its third stage.
	always_ff @(posedge clk) begin
		part_q <= view.ext_in * view.ext_mid;
		count_q <= INDEX_W'(part_q) * INDEX_W'(view.ext_out);
	end

	always_comb begin
		pass_n.cmd = cmd_s1;
		unique case (n_act)
			2'd3: begin
				pass_n.c_in = c2_s1; pass_n.c_mid = c1_s1; pass_n.c_out = c0_s1;
			end
			2'd2: begin
				pass_n.c_in = c1_s1; pass_n.c_mid = c0_s1; pass_n.c_out = '0;
			end
			2'd1: begin
				pass_n.c_in = c0_s1; pass_n.c_mid = '0; pass_n.c_out = '0;
			end
			default: begin
				pass_n.c_in = '0; pass_n.c_mid = '0; pass_n.c_out = '0;
			end
		endcase
		if (!cmd_s1) begin
			pass_n.err = ERR_OK;
		end else if (n_act == 2'd0) begin
			pass_n.err = ERR_SCALAR;
		end else if (pass_n.c_in >= view.ext_in || pass_n.c_mid >= view.ext_mid
				|| pass_n.c_out >= view.ext_out) begin
			pass_n.err = ERR_COORD;
		end else begin
			pass_n.err = ERR_OK;
		end
	end

	assign err3 = pass_s2.cmd ? pass_s2.err : ((li_s2 >= count_q) ? ERR_LOGICAL : ERR_OK);

	always_comb begin
		pass3_n = pass_s2;
		pass3_n.err = err3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd;
			li_s1 <= logical_index;
			c0_s1 <= coord_0;
			c1_s1 <= coord_1;
			c2_s1 <= coord_2;
			li_s2 <= li_s1;
			pass_s2 <= pass_n;
			li_s3 <= li_s2;
			pass_s3 <= pass3_n;
		end
	end

	assign out_valid = valid_s3;
	assign out_index = li_s3;
	assign out_pass = pass_s3;

endmodule
`default_nettype wire

@@ rtl/stad_back.sv @@
`default_nettype none
module stad_back import stad_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire pass_t                  in_pass,
	input  wire logic [2*EXT_W-1:0]     div_word,
	input  wire view_t                  view,
	output logic                        out_valid,
	output logic [OFFSET_W-1:0]         flat_offset,
	output logic [1:0]                  error_code
);

	logic [EXT_W-1:0]    c_mid, c_out;
	logic                valid_s1, valid_s2;
	logic [PROD_W-1:0]   p_in_s1, p_mid_s1, p_out_s1;
	logic [1:0]          err_s1, err_s2;
	logic [OFFSET_W-1:0] off_s2;
	logic [OFFSET_W-1:0] sum;

	// For a logical index the two outer coordinates come out of the second
	// divider: remainder on top, quotient below.
	assign c_mid = in_pass.cmd ? in_pass.c_mid : div_word[2*EXT_W-1:EXT_W];
	assign c_out = in_pass.cmd ? in_pass.c_out : div_word[EXT_W-1:0];

	assign sum = OFFSET_W'(view.base) + OFFSET_W'(p_in_s1) + OFFSET_W'(p_mid_s1)
		+ OFFSET_W'(p_out_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_in_s1 <= in_pass.c_in * view.str_in;
			p_mid_s1 <= c_mid * view.str_mid;
			p_out_s1 <= c_out * view.str_out;
			err_s1 <= in_pass.err;
			off_s2 <= (err_s1 == ERR_OK) ? sum : '0;
			err_s2 <= err_s1;
		end
	end

	assign out_valid = valid_s2;
	assign flat_offset = off_s2;
	assign error_code = err_s2;

endmodule
`default_nettype wire

@@ rtl/strided_tensor_address_generator.sv @@
`default_nettype none
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: index, coords; tuser: cmd
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: flat_offset, error_code
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// One item enters per cycle unless the output stalls or a register write is pending.
// The pipeline is three front stages, then bit-per-stage dividers with 32 stages for
// the inner coordinate and 16 for the outer two, then two back stages.
// Reset clears the configuration to a scalar view and empties the pipeline.
// A stall at the output holds every stage at once; nothing is dropped.
// A register write waits until no item is in flight and holds off new items.
module strided_tensor_address_generator import stad_pkg::*; #(
	parameter int MAX_DIMS = 3
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// logical_index[47:0], coord_0[63:48], coord_1[79:64], coord_2[95:80]
	input  wire logic [95:0]  s_axis_tdata,
	// cmd[0]
	input  wire logic         s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// flat_offset[33:0], error_code[35:34], zero[39:36]
	output logic [39:0]       m_axis_tdata,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	logic [1:0]        num_dims_q;
	logic [BASE_W-1:0] base_q;
	logic [EXT_W-1:0]  ext0_q, ext1_q, ext2_q, str0_q, str1_q, str2_q;
	logic [1:0]        n_act;
	view_t             view;
	logic              en;
	logic              in_acc;
	logic              out_acc;
	logic [5:0]        inflight_q;

	logic                  f_valid;
	logic [INDEX_W-1:0]    f_index;
	pass_t                 f_pass;

	logic                  v1 [Q1_BITS+1];
	logic [EXT_W+Q1_BITS-1:0] w1 [Q1_BITS+1];
	pass_t                 p1 [Q1_BITS+1];
	logic                  v2 [Q2_BITS+1];
	logic [EXT_W+Q2_BITS-1:0] w2 [Q2_BITS+1];
	pass_t                 p2 [Q2_BITS+1];

	logic [OFFSET_W-1:0]   flat_offset;
	logic [1:0]            error_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_dims_q <= '0;
			base_q <= '0;
			ext0_q <= EXT_W'(1);
			ext1_q <= EXT_W'(1);
			ext2_q <= EXT_W'(1);
			str0_q <= '0;
			str1_q <= '0;
			str2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUM_DIMS:    num_dims_q <= cfg_data[1:0];
				REG_BASE_OFFSET: base_q <= cfg_data;
				REG_EXTENT_0:    ext0_q <= cfg_data[EXT_W-1:0];
				REG_EXTENT_1:    ext1_q <= cfg_data[EXT_W-1:0];
				REG_EXTENT_2:    ext2_q <= cfg_data[EXT_W-1:0];
				REG_STRIDE_0:    str0_q <= cfg_data[EXT_W-1:0];
				REG_STRIDE_1:    str1_q <= cfg_data[EXT_W-1:0];
				REG_STRIDE_2:    str2_q <= cfg_data[EXT_W-1:0];
			endcase
		end
	end

	// Items between input and output acceptance, including a waiting result.
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_acc && !out_acc) begin
			inflight_q <= inflight_q + 6'd1;
		end else if (!in_acc && out_acc) begin
			inflight_q <= inflight_q - 6'd1;
		end
	end

	assign cfg_ready = (inflight_q == 6'd0);
	assign n_act = (num_dims_q > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : num_dims_q;
	assign view = map_view(n_act, base_q, ext0_q, ext1_q, ext2_q, str0_q, str1_q, str2_q);

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && !cfg_valid;

	stad_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_acc),
		.cmd(s_axis_tuser),
		.logical_index(s_axis_tdata[47:0]),
		.coord_0(s_axis_tdata[63:48]),
		.coord_1(s_axis_tdata[79:64]),
		.coord_2(s_axis_tdata[95:80]),
		.n_act(n_act), .view(view),
		.out_valid(f_valid), .out_index(f_index), .out_pass(f_pass)
	);

	// The quotient of the inner division is below 2^32 for any index in range,
	// so the top 16 index bits already form a valid partial remainder.
	assign v1[0] = f_valid;
	assign w1[0] = f_index;
	assign p1[0] = f_pass;

	for (genvar i = 0; i < Q1_BITS; i++) begin : g_div1
		stad_div_step #(.K(Q1_BITS)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v1[i]), .in_word(w1[i]), .in_pass(p1[i]),
			.divisor(view.ext_in),
			.out_valid(v1[i+1]), .out_word(w1[i+1]), .out_pass(p1[i+1])
		);
	end

	always_comb begin
		p2[0] = p1[Q1_BITS];
		if (!p1[Q1_BITS].cmd) begin
			p2[0].c_in = w1[Q1_BITS][EXT_W+Q1_BITS-1:Q1_BITS];
		end
	end
	assign v2[0] = v1[Q1_BITS];
	assign w2[0] = w1[Q1_BITS][Q1_BITS-1:0];

	for (genvar i = 0; i < Q2_BITS; i++) begin : g_div2
		stad_div_step #(.K(Q2_BITS)) u_step (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v2[i]), .in_word(w2[i]), .in_pass(p2[i]),
			.divisor(view.ext_mid),
			.out_valid(v2[i+1]), .out_word(w2[i+1]), .out_pass(p2[i+1])
		);
	end

	stad_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v2[Q2_BITS]), .in_pass(p2[Q2_BITS]), .div_word(w2[Q2_BITS]),
		.view(view),
		.out_valid(m_axis_tvalid), .flat_offset(flat_offset), .error_code(error_code)
	);

	assign m_axis_tdata = {4'b0000, error_code, flat_offset};

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && error_code != ERR_OK |-> flat_offset == '0)
		else $error("nonzero offset reported with an error");

	a_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && error_code == ERR_SCALAR |-> n_act == 2'd0)
		else $error("scalar error on a view with dimensions");

	a_inner_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v1[Q1_BITS] && !p1[Q1_BITS].cmd && p1[Q1_BITS].err == ERR_OK
		|-> w1[Q1_BITS][EXT_W+Q1_BITS-1:Q1_BITS] < view.ext_in)
		else $error("inner coordinate past its extent");

	a_outer_quot: assert property (@(posedge clk) disable iff (!arst_n)
		v2[Q2_BITS] && !p2[Q2_BITS].cmd && p2[Q2_BITS].err == ERR_OK
		|-> w2[Q2_BITS][EXT_W-1:0] < view.ext_out)
		else $error("outer coordinate past its extent");

endmodule
`default_nettype wire
